/* hw/rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted during reset
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, muted during reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/nrbd_pkg.sv */
package nrbd_pkg;

  localparam int VALUE_W  = 32;
  localparam int WEIGHT_W = 31;
  localparam int DERIV_W  = 2;
  localparam int BASIS_W  = 3;
  localparam int FRAC_BITS = 20;
  localparam int DIV_STEPS = 33;

  localparam logic REG_DEGREE = 1'b0;
  localparam logic REG_DERIV  = 1'b1;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_W_RD,
    ST_W_MUL,
    ST_W_ACC,
    ST_R_RD,
    ST_R_MUL,
    ST_R_BASE,
    ST_R_RRD,
    ST_R_RMUL,
    ST_R_TERM,
    ST_R_SUB,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_END,
    ST_O_RD,
    ST_O_LATCH,
    ST_O_WAIT
  } state_t;

  // binomial coefficients C(j,k), row j, column k
  localparam logic [7:0] BINOM [0:7][0:7] = '{
    '{8'd1, 8'd0, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
    '{8'd1, 8'd1, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
    '{8'd1, 8'd2, 8'd1,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
    '{8'd1, 8'd3, 8'd3,  8'd1,  8'd0,  8'd0,  8'd0, 8'd0},
    '{8'd1, 8'd4, 8'd6,  8'd4,  8'd1,  8'd0,  8'd0, 8'd0},
    '{8'd1, 8'd5, 8'd10, 8'd10, 8'd5,  8'd1,  8'd0, 8'd0},
    '{8'd1, 8'd6, 8'd15, 8'd20, 8'd15, 8'd6,  8'd1, 8'd0},
    '{8'd1, 8'd7, 8'd21, 8'd35, 8'd35, 8'd21, 8'd7, 8'd1}
  };

  // Q12.20 product rounding, half away from zero
  function automatic logic signed [63:0] rnd_q(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    r = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return p[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

/* hw/rtl/nrbd_if.sv */
interface nrbd_sample_if import nrbd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  bspline_value;
  logic        [WEIGHT_W-1:0] weight;
  modport source (output valid, bspline_value, weight, input ready);
  modport sink (input valid, bspline_value, weight, output ready);
endinterface

interface nrbd_result_if import nrbd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] basis_value;
  logic        [DERIV_W-1:0] deriv_index;
  logic        [BASIS_W-1:0] basis_index;
  logic                      last;
  logic                      div_error;
  modport source (output valid, basis_value, deriv_index, basis_index, last, div_error,
                  input ready);
  modport sink (input valid, basis_value, deriv_index, basis_index, last, div_error,
                output ready);
endinterface

/* hw/rtl/nurbs_rational_basis_derivs_top.sv */
// Rational basis derivatives for one knot span. Items (B-spline value plus control point
// weight) are taken one per cycle while the source offers them, in derivative-major order,
// until (d+1)(p+1) have arrived; no input is taken again until every result of the set has
// been delivered. Each term of the weight function sums is read, multiplied and accumulated;
// each rational value is read, multiplied and taken as base, gets a read, multiply, term
// and subtract step per lower derivative, and then passes the 33-step restoring divider;
// each result is read, latched and held until taken. Loaded values and rational results
// each sit in a single-port synchronous memory of (MAX_DEGREE+1)(MAX_DERIV+1) words.
module nurbs_rational_basis_derivs_top import nrbd_pkg::*; #(
  parameter int MAX_DEGREE  = 7,
  parameter int MAX_DERIV   = 3,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  nrbd_sample_if.sink   samples,
  nrbd_result_if.source results,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int NB    = MAX_DEGREE + 1;
  localparam int ND    = MAX_DERIV + 1;
  localparam int DEPTH = NB * ND;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IXW   = $clog2(NB);
  localparam int NW    = $clog2(NB + 1);
  localparam int JW    = (ND > 1) ? $clog2(ND) : 1;
  localparam int SAT_W = (VALUE_WIDTH < 21) ? 21 : ((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH);
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  function automatic logic signed [31:0] sat_q(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x;
    if (x > SAT_HI) y = SAT_HI;
    if (x < SAT_LO) y = SAT_LO;
    return 32'(y);
  endfunction

  // configuration
  logic [2:0] degree;
  logic [1:0] deriv_order;
  logic       cfg_wr;
  logic [NW-1:0] nb;
  logic [JW-1:0] d_eff;
  logic [CW-1:0] total;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DERIV) ? {30'd0, deriv_order} : {29'd0, degree};

  always_ff @(posedge clk) begin
    if (rst) begin
      degree      <= 3'd3;
      deriv_order <= 2'd1;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DEGREE) degree <= pwdata[2:0];
      else deriv_order <= pwdata[1:0];
    end
  end

  always_comb begin
    nb    = (32'(degree) > MAX_DEGREE) ? NW'(NB) : NW'(degree) + NW'(1);
    d_eff = (32'(deriv_order) > MAX_DERIV) ? JW'(MAX_DERIV) : JW'(deriv_order);
    total = CW'((32'(d_eff) + 1) * 32'(nb));
  end

  // memories
  logic signed [31:0] bs_mem  [DEPTH];
  logic signed [31:0] rat_mem [DEPTH];
  logic signed [31:0] bs_rd, rat_rd;
  logic [AW-1:0] bs_addr, rat_addr;
  logic bs_we, rat_we;
  logic signed [31:0] rat_wdata;

  // control and datapath registers
  state_t state, state_next;
  logic [CW-1:0] load_cnt;
  logic [IXW-1:0] col;
  logic [AW-1:0] addr, row_base, rbase;
  logic [IXW-1:0] i_idx;
  logic [JW-1:0] j_idx, k_idx;
  logic signed [63:0] acc, prod, term;
  logic signed [31:0] den [ND];
  logic [31:0] weights [NB];
  logic err;
  logic [31:0] b_mag, rem;
  logic [32:0] num_lo, quo;
  logic neg, ovf;
  logic [5:0] dcnt;
  logic out_valid;
  logic signed [31:0] out_value;
  logic [JW-1:0] out_j;
  logic [IXW-1:0] out_i;
  logic out_last, out_err;

  logic in_acc, out_acc;
  logic i_end, j_end, k_end;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] acc_w;
  logic signed [63:0] rp;
  logic signed [8:0] coef;
  logic [63:0] a_mag;
  logic [83:0] num;
  logic [32:0] trial;
  logic trial_ge;
  logic signed [63:0] q_val;
  logic signed [32:0] d33;

  assign in_acc  = samples.valid & samples.ready;
  assign out_acc = out_valid & results.ready;
  assign i_end   = (NW'(i_idx) == nb - NW'(1));
  assign j_end   = (j_idx == d_eff);
  assign k_end   = (k_idx == j_idx);

  assign samples.ready       = (state == ST_LOAD);
  assign results.valid       = out_valid;
  assign results.basis_value = out_value;
  assign results.deriv_index = DERIV_W'(out_j);
  assign results.basis_index = BASIS_W'(out_i);
  assign results.last        = out_last;
  assign results.div_error   = out_err;

  always_comb begin
    bs_addr  = addr;
    rat_addr = addr;
    if (state == ST_R_RD) bs_addr = row_base + AW'(i_idx);
    if (state == ST_R_RRD) rat_addr = rbase + AW'(i_idx);
    if (state == ST_DIV_END) rat_addr = row_base + AW'(i_idx);
    if (state == ST_LOAD) bs_addr = load_cnt[AW-1:0];
    bs_we  = in_acc;
    rat_we = (state == ST_DIV_END);
  end

  always_ff @(posedge clk) begin
    if (bs_we) bs_mem[bs_addr] <= samples.bspline_value;
    bs_rd <= bs_mem[bs_addr];
  end

  always_ff @(posedge clk) begin
    if (rat_we) rat_mem[rat_addr] <= rat_wdata;
    rat_rd <= rat_mem[rat_addr];
  end

  // arithmetic helpers
  always_comb begin
    if (state == ST_R_RMUL) begin
      mul_a = den[k_idx];
      mul_b = rat_rd;
    end else begin
      mul_a = bs_rd;
      mul_b = $signed(weights[i_idx]);
    end
    rp    = rnd_q(prod);
    acc_w = acc + rp;
    coef  = $signed({1'b0, BINOM[3'(j_idx)][3'(k_idx)]});
    a_mag = acc[63] ? 64'(-acc) : 64'(acc);
    d33   = {den[0][31], den[0]};
    num   = {a_mag, 20'd0} + 84'(b_mag >> 1);
    trial = {rem, num_lo[32]};
    trial_ge = (trial >= {1'b0, b_mag});
    q_val = neg ? -$signed({31'd0, quo}) : $signed({31'd0, quo});
    if (ovf) q_val = neg ? SAT_LO : SAT_HI;
    rat_wdata = sat_q(q_val);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:     if (in_acc && load_cnt == total - CW'(1)) state_next = ST_W_RD;
      ST_W_RD:     state_next = ST_W_MUL;
      ST_W_MUL:    state_next = ST_W_ACC;
      ST_W_ACC: begin
        if (!i_end) state_next = ST_W_RD;
        else if (k_idx != d_eff) state_next = ST_W_RD;
        // with only row zero the error flag is not registered yet
        else if ((k_idx == '0) ? (sat_q(acc_w) == 32'sd0) : err) state_next = ST_O_RD;
        else state_next = ST_R_RD;
      end
      ST_R_RD:     state_next = ST_R_MUL;
      ST_R_MUL:    state_next = ST_R_BASE;
      ST_R_BASE:   state_next = (j_idx == '0) ? ST_DIV_INIT : ST_R_RRD;
      ST_R_RRD:    state_next = ST_R_RMUL;
      ST_R_RMUL:   state_next = ST_R_TERM;
      ST_R_TERM:   state_next = ST_R_SUB;
      ST_R_SUB:    state_next = k_end ? ST_DIV_INIT : ST_R_RRD;
      ST_DIV_INIT: state_next = ST_DIV_STEP;
      ST_DIV_STEP: if (dcnt == 6'(DIV_STEPS)) state_next = ST_DIV_END;
      ST_DIV_END:  state_next = (j_end && i_end) ? ST_O_RD : ST_R_RD;
      ST_O_RD:     state_next = ST_O_LATCH;
      ST_O_LATCH:  state_next = ST_O_WAIT;
      ST_O_WAIT:   if (out_acc) state_next = out_last ? ST_LOAD : ST_O_RD;
      default:     state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else state <= state_next;
  end

  // control counters with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      load_cnt  <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        load_cnt <= '0;
        col      <= '0;
      end else if (in_acc) begin
        load_cnt <= (load_cnt == total - CW'(1)) ? '0 : load_cnt + CW'(1);
        col      <= (NW'(col) == nb - NW'(1)) ? '0 : col + IXW'(1);
      end
      if (state == ST_O_LATCH) out_valid <= 1'b1;
      else if (out_acc) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) weights[col] <= {1'b0, samples.weight};
    case (state)
      ST_LOAD: begin
        addr  <= '0;
        i_idx <= '0;
        j_idx <= '0;
        k_idx <= '0;
        acc   <= '0;
      end
      ST_W_MUL: prod <= 64'(mul_a * mul_b);
      ST_W_ACC: begin
        addr <= addr + AW'(1);
        if (i_end) begin
          den[k_idx] <= sat_q(acc_w);
          if (k_idx == '0) err <= (sat_q(acc_w) == 32'sd0);
          acc   <= '0;
          i_idx <= '0;
          if (k_idx != d_eff) begin
            k_idx <= k_idx + JW'(1);
          end else begin
            j_idx    <= '0;
            row_base <= '0;
            addr     <= '0;
          end
        end else begin
          acc   <= acc_w;
          i_idx <= i_idx + IXW'(1);
        end
      end
      ST_R_MUL: prod <= 64'(mul_a * mul_b);
      ST_R_BASE: begin
        acc   <= rp;
        k_idx <= JW'(1);
        rbase <= row_base - AW'(nb);
      end
      ST_R_RMUL: prod <= 64'(mul_a * mul_b);
      ST_R_TERM: term <= 64'(coef * 45'(rp));
      ST_R_SUB: begin
        acc <= acc - term;
        if (!k_end) begin
          k_idx <= k_idx + JW'(1);
          rbase <= rbase - AW'(nb);
        end
      end
      ST_DIV_INIT: begin
        b_mag  <= 32'(den[0][31] ? -d33 : d33);
        neg    <= acc[63] ^ den[0][31];
        dcnt   <= '0;
        quo    <= '0;
      end
      ST_DIV_STEP: begin
        if (dcnt == '0) begin
          // first step loads the scaled numerator; b_mag is now settled
          ovf    <= (a_mag >= {20'd0, b_mag, 12'd0});
          rem    <= 32'(num[83:33]);
          num_lo <= num[32:0];
          dcnt   <= 6'd1;
        end else begin
          rem    <= trial_ge ? 32'(trial - {1'b0, b_mag}) : 32'(trial);
          quo    <= {quo[31:0], trial_ge};
          num_lo <= {num_lo[31:0], 1'b0};
          dcnt   <= dcnt + 6'd1;
        end
      end
      ST_DIV_END: begin
        if (j_end) begin
          j_idx    <= '0;
          row_base <= '0;
          if (!i_end) i_idx <= i_idx + IXW'(1);
          else begin
            i_idx <= '0;
            addr  <= '0;
          end
        end else begin
          j_idx    <= j_idx + JW'(1);
          row_base <= row_base + AW'(nb);
        end
      end
      ST_O_LATCH: begin
        out_value <= err ? 32'sd0 : rat_rd;
        out_err   <= err;
        out_j     <= j_idx;
        out_i     <= i_idx;
        out_last  <= (CW'(addr) == total - CW'(1));
      end
      ST_O_WAIT: begin
        if (out_acc) begin
          addr <= addr + AW'(1);
          if (i_end) begin
            i_idx <= '0;
            j_idx <= j_idx + JW'(1);
          end else begin
            i_idx <= i_idx + IXW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/nrbd_checker.sv */
`include "assert_macros.svh"

module nrbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        out_last,
  input logic        out_err
);

  // a waiting result holds until taken
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // no item taken while a result is pending
  `CHK_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready)

  // zero weight function gives zero results
  `CHK_IMPL(a_err_zero, clk, rst, out_valid && out_err, out_value == 32'd0)

  // the set ends after its last result
  `CHK_NEXT(a_last_ends, clk, rst, out_valid && out_ready && out_last, !out_valid)

endmodule

bind nurbs_rational_basis_derivs_top nrbd_checker u_nrbd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_value (results.basis_value),
  .out_last  (results.last),
  .out_err   (results.div_error)
);

/* verif/nurbs_rational_basis_derivs_top_tb.sv */
module nurbs_rational_basis_derivs_top_tb;
  import nrbd_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  bspline_value;
    logic        [WEIGHT_W-1:0] weight;
  } sample_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] basis_value;
    logic        [DERIV_W-1:0] deriv_index;
    logic        [BASIS_W-1:0] basis_index;
    logic                      last;
    logic                      div_error;
  } basis_t;

  localparam logic [2:0] ADDR_DEGREE = 3'd0;
  localparam logic [2:0] ADDR_DERIV  = 3'd4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nrbd_sample_if samples ();
  nrbd_result_if results ();

  nurbs_rational_basis_derivs_top uut (
    .clk(clk), .rst(rst), .samples(samples.sink), .results(results.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [63:0] spline_mem [0:31];
  logic signed [63:0] weight_mem [0:7];
  logic signed [63:0] wsum [0:3];
  logic signed [63:0] rat [0:31];
  int unsigned cur_degree = 3, cur_deriv = 1, fill = 0;

  sample_t pending_q[$];
  basis_t expected_q[$];
  int errors = 0, mismatches = 0, n_results = 0, n_sets = 0, n_errsets = 0;
  bit quiet = 0;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] p;
    logic [63:0] m;
    p = a * b;
    m = p < 0 ? 64'(-p) : 64'(p);
    m = (m + 64'd524288) >> 20;
    return p < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] qdiv(input logic signed [63:0] num,
                                              input logic signed [63:0] den);
    logic neg;
    logic [63:0] a, b, q1, r, m;
    neg = (num < 0) != (den < 0);
    a = num < 0 ? 64'(-num) : 64'(num);
    b = den < 0 ? 64'(-den) : 64'(den);
    q1 = a / b;
    r = a % b;
    if (q1 >= 64'd4096) return neg ? -64'sd2147483648 : 64'sd2147483647;
    m = (q1 << 20) + ((r << 20) + (b >> 1)) / b;
    return sat32(neg ? -$signed(m) : $signed(m));
  endfunction

  // loads one item and, on a complete set, queues its rational basis values
  task automatic predict_rational(input sample_t s);
    int unsigned nb, total, i, j, k;
    logic signed [63:0] acc;
    logic err;
    nb = cur_degree + 1;
    total = (cur_deriv + 1) * nb;
    if (fill >= total) fill = 0;
    spline_mem[fill] = s.bspline_value;
    weight_mem[fill % nb] = {33'd0, s.weight};
    fill++;
    if (fill < total) return;
    fill = 0;
    for (k = 0; k <= cur_deriv; k++) begin
      acc = 0;
      for (i = 0; i < nb; i++) acc += qmul(spline_mem[k*nb+i], weight_mem[i]);
      wsum[k] = sat32(acc);
    end
    err = wsum[0] == 0;
    n_sets++;
    if (err) n_errsets++;
    for (i = 0; i < nb; i++)
      for (j = 0; j <= cur_deriv; j++) begin
        if (err) begin
          rat[j*nb+i] = 0;
        end else begin
          acc = qmul(spline_mem[j*nb+i], weight_mem[i]);
          for (k = 1; k <= j; k++)
            acc -= $signed({56'd0, BINOM[j][k]}) * qmul(wsum[k], rat[(j-k)*nb+i]);
          rat[j*nb+i] = qdiv(acc, wsum[0]);
        end
      end
    for (i = 0; i < total; i++)
      expected_q.push_back('{rat[i][31:0], DERIV_W'(i / nb), BASIS_W'(i % nb),
                             i + 1 == total, err});
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
      samples.bspline_value <= '0;
      samples.weight <= '0;
    end else if (!samples.valid || samples.ready) begin
      if (samples.valid) predict_rational(pending_q.pop_front());
      if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
        samples.valid <= 1'b1;
        samples.bspline_value <= pending_q[0].bspline_value;
        samples.weight <= pending_q[0].weight;
      end else begin
        samples.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    basis_t got, exp_r;
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      results.ready <= quiet || $urandom_range(99) >= 8;
      if (results.valid && results.ready) begin
        got = '{results.basis_value, results.deriv_index, results.basis_index,
                results.last, results.div_error};
        n_results++;
        if (expected_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (mismatches++ < 10) $display("mismatch: expected %p got %p", exp_r, got);
          end
        end
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_DEGREE) cur_degree = data[2:0];
    else cur_deriv = data[1:0];
    fill = 0;
  endtask

  task automatic drain;
    while (pending_q.size() != 0 || samples.valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (2500) @(posedge clk);
  endtask

  function automatic logic [30:0] rand_weight();
    case ($urandom_range(3))
      0: return 31'($urandom);
      1: return 31'h100000 + 31'($urandom_range(0, 32'h1fffff));
      default: return 31'($urandom_range(32'h40000, 32'h300000));
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed(32'($urandom_range(0, 32'h1fffff))) - 32'sh100000);
      default: return 32'($urandom_range(0, 32'h100000));
    endcase
  endfunction

  // one set with per-column weights repeated on every row, now and then a random weight instead
  task automatic queue_set(input bit zero_w);
    int unsigned nb, total, n;
    logic [30:0] w [0:7];
    nb = cur_degree + 1;
    total = (cur_deriv + 1) * nb;
    for (n = 0; n < nb; n++) w[n] = zero_w ? '0 : rand_weight();
    for (n = 0; n < total; n++)
      pending_q.push_back('{rand_value(),
                            $urandom_range(9) == 0 ? rand_weight() : w[n % nb]});
  endtask

  initial begin
    int phase, sent;
    int unsigned degs [0:5] = '{1, 7, 0, 3, 5, 2};
    int unsigned ders [0:5] = '{0, 3, 2, 1, 3, 0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, zero weight sum, partial set
    apb_write(ADDR_DEGREE, 32'd1);
    apb_write(ADDR_DERIV, 32'd1);
    pending_q.push_back('{32'sh7fffffff, 31'h7fffffff});
    pending_q.push_back('{32'sh80000000, 31'h7fffffff});
    pending_q.push_back('{32'sh00100000, 31'h0});
    pending_q.push_back('{32'sh80000000, 31'h1});
    pending_q.push_back('{32'sh00080000, 31'h100000});
    pending_q.push_back('{32'sh00080000, 31'h100000});
    pending_q.push_back('{32'sh00100000, 31'h200000});
    pending_q.push_back('{-32'sh00100000, 31'h200000});
    pending_q.push_back('{32'sh0, 31'h0});
    pending_q.push_back('{32'sh0, 31'h0});
    pending_q.push_back('{32'sh12345, 31'h0});
    pending_q.push_back('{32'sh0, 31'h0});
    pending_q.push_back('{32'sh00040000, 31'h55555555});
    drain;
    // partial set is restarted by the register write
    apb_write(ADDR_DERIV, 32'd0);
    sent = 13;
    phase = 0;
    while (sent < 410) begin
      if (sent > 200 && sent < 280) quiet = 1; else quiet = 0;
      apb_write(ADDR_DEGREE, degs[phase % 6]);
      apb_write(ADDR_DERIV, ders[phase % 6]);
      repeat (3) begin
        queue_set($urandom_range(11) == 0);
        sent += (ders[phase % 6] + 1) * (degs[phase % 6] + 1);
      end
      if ($urandom_range(3) == 0) begin
        pending_q.push_back('{rand_value(), rand_weight()});
        sent++;
      end
      drain;
      phase++;
    end
    $display("sets completed: %0d (%0d with zero weight sum), results checked: %0d",
             n_sets, n_errsets, n_results);
    if (errors == 0 && expected_q.size() == 0)
      $display("nurbs_rational_basis_derivs_top_tb: done, clean");
    else
      $display("nurbs_rational_basis_derivs_top_tb: done, errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("nurbs_rational_basis_derivs_top_tb: done, errors");
    $finish;
  end

endmodule
